// File: rtl/slug_pkg.sv
// shared types, constants, microcode table and arithmetic helpers of the shuffled lehmer generator
package slug_pkg;

    // field and datapath widths
    localparam int DEV_W        = 31;
    localparam int SEED_W       = 32;
    localparam int MUL_W        = 15;
    localparam int PROD_W       = DEV_W + MUL_W;
    localparam int SLOT_MUL_W   = 33;

    // lehmer constants
    localparam logic [MUL_W-1:0] LEHMER_MUL = 15'd16807;
    localparam logic [DEV_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;

    // table depth default and extra warm-up steps beyond the table fill
    localparam int TABLE_DEPTH_DEF = 32;
    localparam int WARM_EXTRA      = 8;

    // microprogram step addresses
    typedef enum logic [2:0] {
        S_IDLE,
        S_WINIT,
        S_WMUL,
        S_WRED,
        S_WLAST,
        S_NMUL,
        S_NRED,
        S_NOUT
    } step_t;

    typedef enum logic [1:0] {
        GEN_HOLD,
        GEN_START,
        GEN_RED
    } gen_sel_t;

    typedef enum logic [1:0] {
        LAST_HOLD,
        LAST_GEN,
        LAST_RDATA
    } last_sel_t;

    typedef enum logic [1:0] {
        TBL_NONE,
        TBL_FILL,
        TBL_SWAP
    } tbl_op_t;

    // sequencing: dispatch waits for a request word, out waits for a free result register
    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_DISPATCH,
        JMP_LOOP,
        JMP_OUT
    } jmp_t;

    typedef struct packed {
        gen_sel_t  gen_sel;
        logic      prod_ld;
        logic      slot_ld;
        logic      cnt_ld;
        tbl_op_t   tbl_op;
        last_sel_t last_sel;
        logic      out_ld;
        jmp_t      jmp;
        step_t     target;
    } uword_t;

    // control store
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        begin
            w.gen_sel  = GEN_HOLD;
            w.prod_ld  = 1'b0;
            w.slot_ld  = 1'b0;
            w.cnt_ld   = 1'b0;
            w.tbl_op   = TBL_NONE;
            w.last_sel = LAST_HOLD;
            w.out_ld   = 1'b0;
            w.jmp      = JMP_NEXT;
            w.target   = S_IDLE;
            unique case (s)
                S_IDLE:
                begin
                    w.jmp    = JMP_DISPATCH;
                    w.target = S_NMUL;
                end
                S_WINIT:
                begin
                    w.gen_sel = GEN_START;
                    w.cnt_ld  = 1'b1;
                end
                S_WMUL:
                begin
                    w.prod_ld = 1'b1;
                end
                S_WRED:
                begin
                    w.gen_sel = GEN_RED;
                    w.tbl_op  = TBL_FILL;
                    w.jmp     = JMP_LOOP;
                    w.target  = S_WMUL;
                end
                S_WLAST:
                begin
                    w.last_sel = LAST_GEN;
                end
                S_NMUL:
                begin
                    w.prod_ld = 1'b1;
                    w.slot_ld = 1'b1;
                end
                S_NRED:
                begin
                    w.gen_sel = GEN_RED;
                    w.tbl_op  = TBL_SWAP;
                end
                S_NOUT:
                begin
                    w.last_sel = LAST_RDATA;
                    w.out_ld   = 1'b1;
                    w.jmp      = JMP_OUT;
                    w.target   = S_IDLE;
                end
                default:
                begin
                    w.jmp    = JMP_OUT;
                    w.target = S_IDLE;
                end
            endcase
            return w;
        end
    endfunction

    // product mod 2^31-1: fold the high part onto the low part, one conditional subtract
    function automatic logic [DEV_W-1:0] lehmer_reduce(input logic [PROD_W-1:0] p);
        logic [DEV_W:0] s;
        begin
            s = {{(DEV_W+1-(PROD_W-DEV_W)){1'b0}}, p[PROD_W-1:DEV_W]} + {1'b0, p[DEV_W-1:0]};
            if (s >= {1'b0, LEHMER_MOD})
            begin
                s = s - {1'b0, LEHMER_MOD};
            end
            return s[DEV_W-1:0];
        end
    endfunction

    // warm-up start word from the seed register
    function automatic logic [DEV_W-1:0] start_value(input logic [SEED_W-1:0] seed);
        logic [SEED_W-1:0] neg;
        begin
            neg = '0 - seed;
            if (seed[SEED_W-1] && (neg != '0) && (neg < {1'b0, LEHMER_MOD}))
            begin
                return neg[DEV_W-1:0];
            end
            return {{(DEV_W-1){1'b0}}, 1'b1};
        end
    endfunction

endpackage

// File: rtl/slug_req_if.sv
// request channel: valid/ready handshake carrying the restart flag
interface slug_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

// File: rtl/slug_rsp_if.sv
// result channel: valid/ready handshake carrying the uniform deviate
interface slug_rsp_if
    import slug_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [DEV_W-1:0] deviate;

    modport source (output valid, output deviate, input ready);
    modport sink   (input valid, input deviate, output ready);
endinterface

// File: rtl/shuffled_lehmer_uniform_generator_top.sv
// shuffled lehmer uniform generator: microcoded sequencer, shared multiplier, shuffle table
//
//   channel   dir   handshake          payload
//   req       in    valid/ready        restart (1 bit)
//   rsp       out   valid/ready        deviate (31 bits)
//   cfg       in    cfg_wr_en          cfg_wr_data (32 bits signed seed)
//
// a normal word runs the steps accept, multiply, reduce with the table swap, output load;
// the result register is loaded at the output step; two multiplies (the lehmer product and
// the slot reciprocal) and one table read-modify-write per word.
// a warm-up (first word after reset, or restart set) adds a start load, the multiply/reduce
// loop over the shared 31x15 multiplier that fills the table, and a step that loads the last word.
// reset takes effect at once; the table needs no clearing pass, warm-up fills it.
// the next word is accepted while a result waits; the sequencer holds at its output
// step until the result register is free.
module shuffled_lehmer_uniform_generator_top
    import slug_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [SEED_W-1:0] cfg_wr_data,
    slug_req_if.sink          req,
    slug_rsp_if.source        rsp
);

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_DEPTH + WARM_EXTRA);
    localparam int WARM_LAST = TABLE_DEPTH + WARM_EXTRA - 1;

    // slot = last / SLOT_DIV, done as an exact reciprocal multiply and shift
    localparam longint unsigned SLOT_DIV =
        64'd1 + (64'(LEHMER_MOD) - 64'd1) / 64'(TABLE_DEPTH);
    localparam int SLOT_SHIFT = DEV_W + $clog2(SLOT_DIV);
    localparam longint unsigned SLOT_MUL =
        ((64'd1 << SLOT_SHIFT) + SLOT_DIV - 64'd1) / SLOT_DIV;
    localparam int SLOTP_W = DEV_W + SLOT_MUL_W;
    localparam logic [SLOT_MUL_W-1:0] SLOT_MUL_C = SLOT_MUL[SLOT_MUL_W-1:0];

    // sequencer and control state
    step_t              upc_reg, upc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               ov_reg, ov_next;
    logic [SEED_W-1:0]  seed_reg;
    logic [DEV_W-1:0]   gen_reg, gen_next;
    logic [DEV_W-1:0]   last_reg, last_next;

    // payload registers
    logic [PROD_W-1:0]  prod_reg;
    logic [SLOTP_W-1:0] slotp_reg;
    logic [DEV_W-1:0]   rdata_reg;
    logic [DEV_W-1:0]   od_reg;

    // shuffle table
    logic [DEV_W-1:0]   tbl_mem [TABLE_DEPTH];

    uword_t             uw;
    logic               go;
    logic               warm;
    logic [DEV_W-1:0]   red_val;
    logic [SLOTP_W-1:0] slot_q;
    logic [IDX_W-1:0]   slot_idx;
    logic               tbl_we;
    logic               tbl_re;
    logic [IDX_W-1:0]   tbl_wa;

    // control word and step condition
    always_comb
    begin
        uw   = ucode(upc_reg);
        warm = req.restart || (last_reg == '0);
        unique case (uw.jmp)
            JMP_DISPATCH: go = req.valid;
            JMP_OUT:      go = !ov_reg || rsp.ready;
            JMP_NEXT:     go = 1'b1;
            JMP_LOOP:     go = 1'b1;
            default:      go = 1'b1;
        endcase
    end

    // modular reduction and slot index
    always_comb
    begin
        red_val = lehmer_reduce(prod_reg);
        slot_q  = slotp_reg >> SLOT_SHIFT;
        if (slot_q >= SLOTP_W'(TABLE_DEPTH))
        begin
            slot_idx = IDX_W'(TABLE_DEPTH - 1);
        end
        else
        begin
            slot_idx = slot_q[IDX_W-1:0];
        end
    end

    // table port controls
    always_comb
    begin
        tbl_we = 1'b0;
        tbl_re = 1'b0;
        tbl_wa = slot_idx;
        case (uw.tbl_op)
            TBL_FILL:
            begin
                tbl_we = go && (cnt_reg < CNT_W'(TABLE_DEPTH));
                tbl_wa = cnt_reg[IDX_W-1:0];
            end
            TBL_SWAP:
            begin
                tbl_we = go;
                tbl_re = go;
            end
            default:
            begin
                tbl_we = 1'b0;
            end
        endcase
    end

    // next step, counter, generator word and last output
    always_comb
    begin
        upc_next  = upc_reg;
        cnt_next  = cnt_reg;
        gen_next  = gen_reg;
        last_next = last_reg;
        ov_next   = ov_reg && !rsp.ready;

        if (go)
        begin
            unique case (uw.jmp)
                JMP_NEXT:     upc_next = step_t'(upc_reg + 3'd1);
                JMP_DISPATCH: upc_next = warm ? step_t'(upc_reg + 3'd1) : uw.target;
                JMP_LOOP:
                begin
                    if (cnt_reg == '0)
                    begin
                        upc_next = step_t'(upc_reg + 3'd1);
                    end
                    else
                    begin
                        upc_next = uw.target;
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
                JMP_OUT:      upc_next = uw.target;
                default:      upc_next = S_IDLE;
            endcase

            if (uw.cnt_ld)
            begin
                cnt_next = CNT_W'(WARM_LAST);
            end

            case (uw.gen_sel)
                GEN_START: gen_next = start_value(seed_reg);
                GEN_RED:   gen_next = red_val;
                default:   gen_next = gen_reg;
            endcase

            case (uw.last_sel)
                LAST_GEN:   last_next = gen_reg;
                LAST_RDATA: last_next = rdata_reg;
                default:    last_next = last_reg;
            endcase

            if (uw.out_ld)
            begin
                ov_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg  <= S_IDLE;
            cnt_reg  <= '0;
            ov_reg   <= 1'b0;
            seed_reg <= SEED_W'(1);
            gen_reg  <= '0;
            last_reg <= '0;
        end
        else
        begin
            upc_reg  <= upc_next;
            cnt_reg  <= cnt_next;
            ov_reg   <= ov_next;
            gen_reg  <= gen_next;
            last_reg <= last_next;
            if (cfg_wr_en)
            begin
                seed_reg <= cfg_wr_data;
            end
        end
    end

    // multiplier products and result word
    always_ff @(posedge clk)
    begin
        if (go && uw.prod_ld)
        begin
            prod_reg <= PROD_W'(gen_reg) * PROD_W'(LEHMER_MUL);
        end
        if (go && uw.slot_ld)
        begin
            slotp_reg <= SLOTP_W'(last_reg) * SLOTP_W'(SLOT_MUL_C);
        end
        if (go && uw.out_ld)
        begin
            od_reg <= rdata_reg;
        end
    end

    // shuffle table, read-first
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_wa] <= red_val;
        end
        if (tbl_re)
        begin
            rdata_reg <= tbl_mem[slot_idx];
        end
    end

    // handshake outputs
    assign req.ready   = (upc_reg == S_IDLE);
    assign rsp.valid   = ov_reg;
    assign rsp.deviate = od_reg;

endmodule

// File: verif/tb_top.sv
// testbench of the shuffled lehmer generator: directed and random request words, predictor check
module tb_top
    import slug_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH        = TABLE_DEPTH_DEF;
    localparam int          SLOT_W       = $clog2(DEPTH);
    localparam logic [31:0] SLOT_SPAN    = 32'd1 + (32'(LEHMER_MOD) - 32'd1) / DEPTH;
    localparam int          WARM_CYCLES  = 2 * (DEPTH + WARM_EXTRA) + 2;
    localparam int          DRAIN_CYCLES = WARM_CYCLES + 8;
    localparam int          LIMIT_CYCLES = 400000;
    localparam int          RAND_WORDS   = 367;
    localparam int          RAND_CHUNKS  = 3;

    // seeds at the edges of the start rule
    localparam logic [SEED_W-1:0] SEED_CORNERS [6] = '{
        32'h8000_0002,  // most negative seed with a valid start
        32'h8000_0001,  // negation equals the modulus, falls back to 1
        32'h8000_0000,  // negation overflows, falls back to 1
        32'hFFFF_FFFF,  // start 1 by negation
        32'h0000_0000,  // zero seed, start 1
        32'h7FFF_FFFF   // largest positive seed, start 1
    };

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [SEED_W-1:0] cfg_wr_data;

    slug_req_if req_ch ();
    slug_rsp_if rsp_ch ();

    shuffled_lehmer_uniform_generator_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // predictor state
    logic [SEED_W-1:0] seed_reg;
    logic [DEV_W-1:0]  gen_word;
    logic [DEV_W-1:0]  prev_deviate;
    logic [DEV_W-1:0]  shuffle_tbl [DEPTH];
    logic [DEV_W-1:0]  pending_deviates [$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_cnt = 0;
    int checked_cnt  = 0;
    int req_cnt      = 0;
    int restart_cnt  = 0;
    int seed_cnt     = 1;
    int cycle_cnt    = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // one minimal standard step, exact product and remainder
    function automatic logic [DEV_W-1:0] lehmer_advance(input logic [DEV_W-1:0] w);
        bit [63:0] prod;
        prod = 64'(w) * 64'(LEHMER_MUL);
        return DEV_W'(prod % 64'(LEHMER_MOD));
    endfunction

    // warm-up start word: negated seed when it lands in 1..mod-1, else 1
    function automatic logic [DEV_W-1:0] warmup_start(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] mag;
        mag = '0 - s;
        if (s[SEED_W-1] && (mag != '0) && (mag < 32'(LEHMER_MOD)))
        begin
            return mag[DEV_W-1:0];
        end
        return DEV_W'(1);
    endfunction

    // run the warm-up steps and fill the table from the top slot down
    function automatic void refill_shuffle();
        gen_word = warmup_start(seed_reg);
        for (int j = DEPTH + WARM_EXTRA - 1; j >= 0; j--)
        begin
            gen_word = lehmer_advance(gen_word);
            if (j < DEPTH)
            begin
                shuffle_tbl[SLOT_W'(j)] = gen_word;
            end
        end
        prev_deviate = shuffle_tbl[0];
    endfunction

    // deviate that one request word yields
    function automatic logic [DEV_W-1:0] draw_deviate(input logic rs);
        int unsigned       slot;
        logic [SLOT_W-1:0] slot_idx;
        if (rs || (prev_deviate == '0))
        begin
            refill_shuffle();
        end
        gen_word = lehmer_advance(gen_word);
        slot = 32'(prev_deviate) / SLOT_SPAN;
        if (slot >= DEPTH)
        begin
            slot = DEPTH - 1;
        end
        slot_idx              = slot[SLOT_W-1:0];
        prev_deviate          = shuffle_tbl[slot_idx];
        shuffle_tbl[slot_idx] = gen_word;
        return prev_deviate;
    endfunction

    function automatic void note_mismatch(input string what, input logic [DEV_W-1:0] want,
                                          input logic [DEV_W-1:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
        begin
            $display("%s at result %0d: expected %0d, got %0d", what, checked_cnt, want, got);
        end
    endfunction

    // send one request word, idling first at random; valid stays high on return
    task automatic send_request(input logic rs);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.restart <= 1'($urandom);
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid   <= 1'b1;
        req_ch.restart <= rs;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_deviates.push_back(draw_deviate(rs));
        req_cnt++;
        if (rs)
        begin
            restart_cnt++;
        end
    endtask

    // drop valid and wait until every expected deviate is back
    task automatic settle(input int extra);
        req_ch.valid <= 1'b0;
        while (pending_deviates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (extra) @(posedge clk);
    endtask

    // seed register write, only while the block is idle
    task automatic write_seed(input logic [SEED_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 32'($urandom);
        seed_reg = v;
        seed_cnt++;
    endtask

    function automatic logic [SEED_W-1:0] pick_seed();
        logic [SEED_W-1:0] mag;
        case ($urandom_range(7))
            0: return SEED_CORNERS[3'($urandom_range(5))];
            1: return 32'($urandom);
            default:
            begin
                mag = $urandom_range(32'h7FFF_FFFE, 1);
                return '0 - mag;
            end
        endcase
    endfunction

    // the first word after reset warms up from the reset seed
    task automatic test_power_on();
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);
        settle(4);
    endtask

    // each start-rule corner, restart then one plain word
    task automatic test_seed_extremes();
        foreach (SEED_CORNERS[i])
        begin
            write_seed(SEED_CORNERS[i]);
            send_request(1'b1);
            send_request(1'b0);
            settle(4);
        end
    endtask

    // restart on every word repeats the same deviate
    task automatic test_restart_held();
        write_seed(pick_seed());
        repeat (4) send_request(1'b1);
        send_request(1'b0);
        settle(4);
    endtask

    // random traffic under one idling setting, a fresh seed per chunk
    task automatic test_random_traffic(input int spct, input int rpct);
        send_idle_pct  = spct;
        recv_stall_pct = rpct;
        for (int c = 0; c < RAND_CHUNKS; c++)
        begin
            write_seed(pick_seed());
            send_request(1'b1);
            repeat (RAND_WORDS / RAND_CHUNKS - 1) send_request($urandom_range(99) < 4);
            settle(4);
        end
    endtask

    // result checker and receiver stalls
    initial
    begin
        logic [DEV_W-1:0] want;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_deviates.size() == 0)
                begin
                    note_mismatch("unexpected word", '0, rsp_ch.deviate);
                end
                else
                begin
                    want = pending_deviates.pop_front();
                    if (want !== rsp_ch.deviate)
                    begin
                        note_mismatch("deviate mismatch", want, rsp_ch.deviate);
                    end
                end
                checked_cnt++;
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    initial
    begin
        while (cycle_cnt <= LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d deviates outstanding", cycle_cnt,
                 pending_deviates.size());
        $display("end of test: mismatches");
        $finish;
    end

    // main sequence
    initial
    begin
        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.restart <= 1'b0;
        seed_reg       = 32'd1;
        gen_word       = '0;
        prev_deviate   = '0;
        foreach (shuffle_tbl[i])
        begin
            shuffle_tbl[i] = '0;
        end
        send_idle_pct  = 36;
        recv_stall_pct = 84;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on();
        test_seed_extremes();
        test_restart_held();
        test_random_traffic(36, 84);
        test_random_traffic(84, 36);
        test_random_traffic(0, 0);
        settle(DRAIN_CYCLES);

        $display("covered %0d request words (%0d with restart) over %0d seed settings",
                 req_cnt, restart_cnt, seed_cnt);
        $display("checked %0d deviates in %0d cycles, %0d mismatches",
                 checked_cnt, cycle_cnt, mismatch_cnt);
        if ((mismatch_cnt == 0) && (pending_deviates.size() == 0))
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
